FILE: hw/rtl/cpbf_pkg.sv
package cpbf_pkg;

  // Fixed widths of the item fields.
  localparam int unsigned FIELD_BITS     = 16;
  localparam int unsigned IDX_BITS       = 8;
  localparam int unsigned DSQ_BITS       = 33;
  localparam int unsigned DFIX_BITS      = 25;
  localparam int unsigned FRAC_BITS      = 8;
  // Width of the all-ones starting value of the best squared distance.
  localparam int unsigned BEST_INIT_BITS = 34;

  // One input item: a point and the end-of-set flag.
  typedef struct packed {
    logic signed [FIELD_BITS-1:0] x;
    logic signed [FIELD_BITS-1:0] y;
    logic                         last;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [IDX_BITS-1:0]  first_index;
    logic [IDX_BITS-1:0]  second_index;
    logic [DSQ_BITS-1:0]  dist_squared;
    logic [DFIX_BITS-1:0] dist_fixed;
    logic                 no_pair;
    logic                 overflow;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_en;       // store the incoming point
    logic rd_en;       // read one pair of points
    logic sqrt_start;  // start the square root of the best distance
    logic load_out;    // load the result register and clear the best pair
    logic no_pair;     // the set holds fewer than two points
    logic ovf;         // points of this set were dropped
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pipe_busy;   // pair checks still in flight
    logic sqrt_busy;   // square root still iterating
    logic out_free;    // result register can take a new item this cycle
  } dp_status_t;

endpackage

FILE: hw/rtl/cpbf_sqrt.sv
module cpbf_sqrt import cpbf_pkg::*; #(
  parameter int unsigned VAL_BITS = 34
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [VAL_BITS-1:0]               value_i,
  output logic                              busy_o,
  output logic [VAL_BITS/2+FRAC_BITS-1:0]   root_o
);

  localparam int unsigned RW   = VAL_BITS / 2 + FRAC_BITS;
  localparam int unsigned CNTW = $clog2(RW + 1);

  logic [2*RW-1:0] rad_q;
  logic [RW:0]     rem_q;
  logic [RW-1:0]   root_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q;

  logic [RW+2:0]   shifted;
  logic [RW+2:0]   trial;
  logic [RW+2:0]   diff;
  logic            take;

  // One result bit per cycle: bring down the next bit pair and try to subtract.
  always_comb begin
    shifted = {rem_q, rad_q[2*RW-1 -: 2]};
    trial   = {1'b0, root_q, 2'b01};
    take    = (shifted >= trial);
    diff    = shifted - trial;
  end

  // Iteration control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNTW'(RW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Radicand, partial remainder and root. The radicand is scaled up by the
  // fraction bits squared so that the root carries its fraction.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= {value_i, {(2*FRAC_BITS){1'b0}}};
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[2*RW-3:0], 2'b00};
      if (take) begin
        rem_q  <= diff[RW:0];
        root_q <= {root_q[RW-2:0], 1'b1};
      end else begin
        rem_q  <= shifted[RW:0];
        root_q <= {root_q[RW-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

FILE: hw/rtl/cpbf_datapath.sv
module cpbf_datapath import cpbf_pkg::*; #(
  parameter int unsigned MAX_POINTS = 256,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  in_item_t                      in_item_i,
  input  ctrl_cmd_t                     cmd_i,
  input  logic [$clog2(MAX_POINTS)-1:0] wr_addr_i,
  input  logic [$clog2(MAX_POINTS)-1:0] rd_addr_a_i,
  input  logic [$clog2(MAX_POINTS)-1:0] rd_addr_b_i,
  output dp_status_t                    status_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output out_item_t                     out_item_o
);

  localparam int unsigned AW  = $clog2(MAX_POINTS);
  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned DW  = C + 1;
  localparam int unsigned SQW = 2 * DW;
  localparam int unsigned D2W = (SQW > BEST_INIT_BITS) ? SQW : BEST_INIT_BITS;
  localparam int unsigned IW  = (AW > IDX_BITS) ? AW : IDX_BITS;
  localparam int unsigned RW  = D2W / 2 + FRAC_BITS;
  localparam logic [D2W-1:0] BEST_INIT = D2W'({BEST_INIT_BITS{1'b1}});

  // Coordinates: the low COORD_BITS bits of the zero-extended field.
  logic [2*FIELD_BITS-1:0] raw_x;
  logic [2*FIELD_BITS-1:0] raw_y;
  logic [C-1:0]            wr_x;
  logic [C-1:0]            wr_y;

  assign raw_x = {{FIELD_BITS{1'b0}}, in_item_i.x};
  assign raw_y = {{FIELD_BITS{1'b0}}, in_item_i.y};
  assign wr_x  = raw_x[C-1:0];
  assign wr_y  = raw_y[C-1:0];

  // Point store: one write port, two registered read ports.
  logic [2*C-1:0] store_q [MAX_POINTS];
  logic [2*C-1:0] pa_q;
  logic [2*C-1:0] pb_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      store_q[wr_addr_i] <= {wr_x, wr_y};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      pa_q <= store_q[rd_addr_a_i];
      pb_q <= store_q[rd_addr_b_i];
    end
  end

  // Absolute differences of the sign-extended coordinates.
  logic [DW-1:0] ddx;
  logic [DW-1:0] ddy;
  logic [DW-1:0] adx_d;
  logic [DW-1:0] ady_d;

  always_comb begin
    ddx   = {pa_q[2*C-1], pa_q[2*C-1:C]} - {pb_q[2*C-1], pb_q[2*C-1:C]};
    ddy   = {pa_q[C-1], pa_q[C-1:0]} - {pb_q[C-1], pb_q[C-1:0]};
    adx_d = ddx[DW-1] ? (~ddx + DW'(1)) : ddx;
    ady_d = ddy[DW-1] ? (~ddy + DW'(1)) : ddy;
  end

  logic [DW-1:0]  adx_q;
  logic [DW-1:0]  ady_q;
  logic [SQW-1:0] sqx_d;
  logic [SQW-1:0] sqy_d;
  logic [SQW-1:0] sqx_q;
  logic [SQW-1:0] sqy_q;
  logic [D2W-1:0] sum_d;

  assign sqx_d = SQW'(adx_q) * SQW'(adx_q);
  assign sqy_d = SQW'(ady_q) * SQW'(ady_q);
  assign sum_d = D2W'(sqx_q) + D2W'(sqy_q);

  always_ff @(posedge clk_i) begin
    adx_q <= adx_d;
    ady_q <= ady_d;
    sqx_q <= sqx_d;
    sqy_q <= sqy_d;
  end

  // Valid bits and pair indices travel alongside the arithmetic.
  logic          v1_q, v2_q, v3_q;
  logic [AW-1:0] ia1_q, ia2_q, ia3_q;
  logic [AW-1:0] ib1_q, ib2_q, ib3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.rd_en;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ia1_q <= rd_addr_a_i;
    ib1_q <= rd_addr_b_i;
    ia2_q <= ia1_q;
    ib2_q <= ib1_q;
    ia3_q <= ia2_q;
    ib3_q <= ib2_q;
  end

  // Best pair: replaced only by a strictly smaller distance.
  logic [D2W-1:0] best_q;
  logic [AW-1:0]  best_a_q;
  logic [AW-1:0]  best_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q   <= BEST_INIT;
      best_a_q <= '0;
      best_b_q <= '0;
    end else if (cmd_i.load_out) begin
      best_q   <= BEST_INIT;
      best_a_q <= '0;
      best_b_q <= '0;
    end else if (v3_q && (sum_d < best_q)) begin
      best_q   <= sum_d;
      best_a_q <= ia3_q;
      best_b_q <= ib3_q;
    end
  end

  // Square root of the best distance.
  logic [RW-1:0] root;
  logic          sqrt_busy;

  cpbf_sqrt #(
    .VAL_BITS(D2W)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.sqrt_start),
    .value_i(best_q),
    .busy_o (sqrt_busy),
    .root_o (root)
  );

  // Result register.
  logic [IW-1:0] fi_wide;
  logic [IW-1:0] si_wide;
  out_item_t     out_d;
  out_item_t     out_q;
  logic          out_valid_q;
  logic          out_free;

  assign fi_wide  = IW'(best_a_q);
  assign si_wide  = IW'(best_b_q);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_d = '0;
    out_d.overflow = cmd_i.ovf;
    if (cmd_i.no_pair) begin
      out_d.no_pair = 1'b1;
    end else begin
      out_d.first_index  = fi_wide[IDX_BITS-1:0];
      out_d.second_index = si_wide[IDX_BITS-1:0];
      out_d.dist_squared = best_q[DSQ_BITS-1:0];
      out_d.dist_fixed   = root[DFIX_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    status_o.pipe_busy = v1_q || v2_q || v3_q;
    status_o.sqrt_busy = sqrt_busy;
    status_o.out_free  = out_free;
  end

endmodule

FILE: hw/rtl/cpbf_ctrl.sv
module cpbf_ctrl import cpbf_pkg::*; #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_last_i,
  output logic                          in_ready_o,
  input  dp_status_t                    status_i,
  output ctrl_cmd_t                     cmd_o,
  output logic [$clog2(MAX_POINTS)-1:0] wr_addr_o,
  output logic [$clog2(MAX_POINTS)-1:0] rd_addr_a_o,
  output logic [$clog2(MAX_POINTS)-1:0] rd_addr_b_o
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] CAP = CW'(MAX_POINTS);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_SEARCH,
    ST_DRAIN,
    ST_ROOT,
    ST_FINISH
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic [AW-1:0] pi_q, pi_d;
  logic [AW-1:0] pj_q, pj_d;

  logic          accept;
  logic          has_room;
  logic          few_points;
  logic [CW-1:0] last_idx;
  logic          row_end;
  logic          final_pair;

  assign accept     = in_valid_i && (state_q == ST_LOAD);
  assign has_room   = (count_q < CAP);
  assign few_points = (count_q < CW'(2));
  assign last_idx   = count_q - CW'(1);
  assign row_end    = (CW'(pj_q) == last_idx);
  assign final_pair = row_end && ((CW'(pi_q) + CW'(2)) == count_q);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    pi_d    = pi_q;
    pj_d    = pj_q;
    cmd_o   = '0;
    cmd_o.no_pair = few_points;
    cmd_o.ovf     = ovf_q;

    case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (has_room) begin
            cmd_o.wr_en = 1'b1;
            count_d     = count_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_last_i) begin
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        pi_d = '0;
        pj_d = AW'(1);
        state_d = few_points ? ST_FINISH : ST_SEARCH;
      end
      // One pair per cycle, first index outer, second index inner.
      ST_SEARCH: begin
        cmd_o.rd_en = 1'b1;
        if (final_pair) begin
          state_d = ST_DRAIN;
        end else if (row_end) begin
          pi_d = pi_q + AW'(1);
          pj_d = pi_q + AW'(2);
        end else begin
          pj_d = pj_q + AW'(1);
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          cmd_o.sqrt_start = 1'b1;
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (!status_i.sqrt_busy) begin
          state_d = ST_FINISH;
        end
      end
      // Hand the result over and return to an empty set.
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          count_d = '0;
          ovf_d   = 1'b0;
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // State and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      ovf_q   <= 1'b0;
      pi_q    <= '0;
      pj_q    <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      pi_q    <= pi_d;
      pj_q    <= pj_d;
    end
  end

  assign in_ready_o  = (state_q == ST_LOAD);
  assign wr_addr_o   = count_q[AW-1:0];
  assign rd_addr_a_o = pi_q;
  assign rd_addr_b_o = pj_q;

endmodule

FILE: hw/rtl/closest_pair_brute_force_top.sv
// Loading accepts point items in the load state. After the item with last set, the search
// checks one pair per cycle, a rate set by the single two-port read of the point
// store, then drains the distance pipeline and takes the square root of the best
// distance before the result is handed over.
// The result waits in an output register while the next set is loaded.
// Reset (rst_ni low, asynchronous) empties the set; the point store is not cleared.
module closest_pair_brute_force_top import cpbf_pkg::*; #(
  parameter int unsigned MAX_POINTS = 256,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned AW = $clog2(MAX_POINTS);

  ctrl_cmd_t     cmd;
  dp_status_t    status;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;

  // Sequencer for loading, pair search, square root and hand-over.
  cpbf_ctrl #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_item_i.last),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd),
    .wr_addr_o  (wr_addr),
    .rd_addr_a_o(rd_addr_a),
    .rd_addr_b_o(rd_addr_b)
  );

  // Point store, distance pipeline, best pair and result register.
  cpbf_datapath #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .wr_addr_i  (wr_addr),
    .rd_addr_a_i(rd_addr_a),
    .rd_addr_b_i(rd_addr_b),
    .status_o   (status),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o)
  );

endmodule

FILE: sim/closest_pair_checker.sv
module closest_pair_checker import cpbf_pkg::*; #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_item_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned results_o
);

  // Shadow copy of the set being loaded.
  logic signed [FIELD_BITS-1:0] set_x [MAX_POINTS];
  logic signed [FIELD_BITS-1:0] set_y [MAX_POINTS];
  int unsigned points_held;
  logic        points_dropped;

  // Closest pairs predicted but not yet seen on the result channel.
  out_item_t   closest_pairs_due [$];
  int unsigned mismatches;
  int unsigned results_seen;

  // Distance as floor(sqrt(d2) * 256), one result bit per radicand bit pair.
  function automatic logic [DFIX_BITS-1:0] root_q8(input logic [DSQ_BITS-1:0] d2);
    longint unsigned radicand;
    longint unsigned root;
    longint unsigned partial;
    longint unsigned trial;
    radicand = longint'(d2) << (2 * FRAC_BITS);
    root     = 0;
    partial  = 0;
    for (int k = DFIX_BITS - 1; k >= 0; k--) begin
      partial = (partial << 2) | ((radicand >> (2 * k)) & 64'd3);
      trial   = (root << 2) | 64'd1;
      if (partial >= trial) begin
        partial = partial - trial;
        root    = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return DFIX_BITS'(root);
  endfunction

  // Brute-force search over the stored points; a tie keeps the earlier pair.
  function automatic out_item_t closest_of_set();
    out_item_t       res;
    longint unsigned best;
    longint unsigned d2;
    longint          dx;
    longint          dy;
    int unsigned     best_i;
    int unsigned     best_j;
    res          = '0;
    res.overflow = points_dropped;
    if (points_held < 2) begin
      res.no_pair = 1'b1;
      return res;
    end
    best   = (64'd1 << BEST_INIT_BITS) - 1;
    best_i = 0;
    best_j = 0;
    for (int unsigned i = 0; i < points_held; i++) begin
      for (int unsigned j = i + 1; j < points_held; j++) begin
        dx = longint'(set_x[i]) - longint'(set_x[j]);
        dy = longint'(set_y[i]) - longint'(set_y[j]);
        d2 = longint'(dx * dx + dy * dy);
        if (d2 < best) begin
          best   = d2;
          best_i = i;
          best_j = j;
        end
      end
    end
    res.first_index  = IDX_BITS'(best_i);
    res.second_index = IDX_BITS'(best_j);
    res.dist_squared = DSQ_BITS'(best);
    res.dist_fixed   = root_q8(DSQ_BITS'(best));
    return res;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      points_held    = 0;
      points_dropped = 1'b0;
      mismatches     = 0;
      results_seen   = 0;
      closest_pairs_due.delete();
    end else begin
      // Store the accepted point; a last item closes the set and predicts its result.
      if (in_valid_i && in_ready_i) begin
        if (points_held < MAX_POINTS) begin
          set_x[points_held] = in_item_i.x;
          set_y[points_held] = in_item_i.y;
          points_held++;
        end else begin
          points_dropped = 1'b1;
        end
        if (in_item_i.last) begin
          closest_pairs_due.push_back(closest_of_set());
          points_held    = 0;
          points_dropped = 1'b0;
        end
      end
      // Compare each accepted result with the oldest prediction.
      if (out_valid_i && out_ready_i) begin
        results_seen++;
        if (closest_pairs_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, expected nothing, actual %p",
                   $time, out_item_i);
        end else begin
          want = closest_pairs_due.pop_front();
          check_field("first_index", want.first_index, out_item_i.first_index);
          check_field("second_index", want.second_index, out_item_i.second_index);
          check_field("dist_squared", want.dist_squared, out_item_i.dist_squared);
          check_field("dist_fixed", want.dist_fixed, out_item_i.dist_fixed);
          check_field("no_pair", want.no_pair, out_item_i.no_pair);
          check_field("overflow", want.overflow, out_item_i.overflow);
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= closest_pairs_due.size();
    results_o    <= results_seen;
  end

endmodule

FILE: sim/testbench.sv
module testbench import cpbf_pkg::*;;

  localparam int unsigned MAX_POINTS  = 256;
  localparam int unsigned ITEM_TARGET = 1350;
  localparam int unsigned QUIET_ITEMS = 150;
  localparam int unsigned HOLD_CYCLES = 500;

  // How the coordinates of one random set are spread.
  typedef enum int unsigned {SPREAD_WIDE, SPREAD_CLUSTER, SPREAD_EDGE} spread_e;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned points_sent;
  bit          quiet;
  bit          held_off;

  closest_pair_brute_force_top #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(FIELD_BITS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  closest_pair_checker #(
    .MAX_POINTS(MAX_POINTS)
  ) checker_inst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_i  (out_item_o),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (results_seen)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Offer one point, with an occasional idle burst ahead of it, and wait for acceptance.
  task automatic send_point(input logic signed [FIELD_BITS-1:0] x,
                            input logic signed [FIELD_BITS-1:0] y, input logic last);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_item_i.x    <= x;
    in_item_i.y    <= y;
    in_item_i.last <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    points_sent++;
  endtask

  function automatic logic [FIELD_BITS-1:0] pick_coord(input spread_e spread,
                                                       input logic [FIELD_BITS-1:0] base);
    case (spread)
      SPREAD_CLUSTER: return {base[FIELD_BITS-1:4], 4'($urandom)};
      SPREAD_EDGE: begin
        case ($urandom_range(0, 5))
          0: return 16'h8000;
          1: return 16'h8001;
          2: return 16'h7FFF;
          3: return 16'h7FFE;
          4: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // One whole set of random points; the final point carries last.
  task automatic send_set(input int unsigned count, input spread_e spread);
    logic [FIELD_BITS-1:0] base_x;
    logic [FIELD_BITS-1:0] base_y;
    base_x = 16'($urandom);
    base_y = 16'($urandom);
    for (int unsigned n = 0; n < count; n++) begin
      send_point(pick_coord(spread, base_x), pick_coord(spread, base_y), n == count - 1);
    end
  endtask

  // Result side: short random stalls, and one long hold-off that backs up the block.
  initial begin
    out_ready_i = 1'b0;
    held_off    = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held_off && results_seen >= 12) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        held_off = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Stimulus and verdict.
  initial begin
    bit          full_done;
    bit          spill_done;
    int unsigned pick;
    int unsigned count;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    points_sent = 0;
    quiet       = 1'b0;
    full_done   = 1'b0;
    spill_done  = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A lone point has no pair.
    send_point(16'sd0, 16'sd0, 1'b1);
    // Opposite corners give the largest distance, both diagonals.
    send_point(-16'sd32768, -16'sd32768, 1'b0);
    send_point(16'sd32767, 16'sd32767, 1'b1);
    send_point(16'sd32767, -16'sd32768, 1'b0);
    send_point(-16'sd32768, 16'sd32767, 1'b1);
    // Coincident points give zero distance.
    send_point(16'sd5, -16'sd7, 1'b0);
    send_point(16'sd5, -16'sd7, 1'b1);
    // Equal spacing: every neighbor ties, so the first pair must win.
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd3, 16'sd4, 1'b0);
    send_point(16'sd6, 16'sd8, 1'b0);
    send_point(16'sd9, 16'sd12, 1'b1);
    // The closest pair is found late and not adjacent.
    send_point(16'sd100, 16'sd100, 1'b0);
    send_point(-16'sd100, -16'sd100, 1'b0);
    send_point(16'sd1000, 16'sd1000, 1'b0);
    send_point(-16'sd99, -16'sd101, 1'b1);
    // Alternating bit patterns.
    send_point(16'sh5555, 16'shAAAA, 1'b0);
    send_point(16'shAAAA, 16'sh5555, 1'b1);
    // A lone point again right after a two-point set.
    send_point(-16'sd1, -16'sd1, 1'b1);

    // Random sets, mostly small, with one full store and one that spills over.
    while (points_sent < ITEM_TARGET) begin
      quiet = (points_sent + QUIET_ITEMS >= ITEM_TARGET);
      if (!full_done && points_sent >= 300) begin
        send_set(MAX_POINTS, SPREAD_WIDE);
        full_done = 1'b1;
      end else if (!spill_done && points_sent >= 700) begin
        send_set(MAX_POINTS + $urandom_range(1, 6), spread_e'($urandom_range(0, 2)));
        spill_done = 1'b1;
      end else begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          count = 1;
        end else if (pick == 1) begin
          count = $urandom_range(20, 40);
        end else begin
          count = $urandom_range(2, 10);
        end
        send_set(count, spread_e'($urandom_range(0, 2)));
      end
    end
    in_valid_i <= 1'b0;

    // Drain, then allow time for any stray result to show up. The pending count
    // only reflects the final item after the checker has seen its acceptance.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS closest_pair_brute_force_top");
    end else begin
      $display("FAIL closest_pair_brute_force_top");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("FAIL closest_pair_brute_force_top");
    $finish;
  end

endmodule
